// ----- rtl/flag_register_bitmap_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// flag register bitmap allocator assertion macros
// concurrent assertion wrappers clocked on i_clk, held off during i_rst_n
// ----------------------------------------------------------------------------
`ifndef FLAG_REGISTER_BITMAP_ALLOCATOR_ASSERT_SVH
`define FLAG_REGISTER_BITMAP_ALLOCATOR_ASSERT_SVH

// assertion with a fixed failure message
`define FRBA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("frba assertion failed");

// assertion with a caller supplied failure message
`define FRBA_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

// ----- rtl/frba_pkg.sv -----
// ----------------------------------------------------------------------------
// frba_pkg
// types, command and status codes and constants of the flag slot allocator
// ----------------------------------------------------------------------------
package frba_pkg;

    localparam int unsigned SLOT_COUNT_DEFAULT = 64;
    localparam int unsigned SLOT_INDEX_W       = 6;
    localparam int unsigned LOCK_W             = 8;
    localparam int unsigned FLAG_COUNT_W       = 4;

    localparam logic [FLAG_COUNT_W-1:0] FLAG_COUNT_RESET = 4'd4;

    localparam logic [63:0]       PAIR_EVEN_MASK = 64'h5555_5555_5555_5555;
    localparam logic [LOCK_W-1:0] LOCK_PAIR_MASK = 8'h55;

    localparam logic [2:0] CMD_ALLOC_VIRTUAL   = 3'd0;
    localparam logic [2:0] CMD_ALLOC_PHYSICAL  = 3'd1;
    localparam logic [2:0] CMD_LOCK            = 3'd2;
    localparam logic [2:0] CMD_RELEASE         = 3'd3;
    localparam logic [2:0] CMD_CAN_LOCK        = 3'd4;
    localparam logic [2:0] CMD_FREE_UNLOCKED   = 3'd5;
    localparam logic [2:0] CMD_ASSIGN_PHYSICAL = 3'd6;

    localparam logic [1:0] SLOT_WIDTH_PAIR = 2'd2;

    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_OUT_OF_SLOTS   = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL_RELOCK = 2'd2;
    localparam logic [1:0] STATUS_NOT_PHYSICAL   = 2'd3;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [1:0]              slot_width;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic                    allow_relock;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_INDEX_W-1:0] result_index;
        logic                    answer_bit;
    } t_out_beat;

endpackage

// ----- rtl/flag_register_bitmap_allocator.sv -----
// an accepted input beat is held in the input register, then its result beat in the result register
// throughput: one command per cycle unless the output stalls; the maps update only when a command advances
// the input register frees whenever the result register empties or is taken
// reset (synchronous, i_rst_n low): all slots free, no locks, pointer at 0,
// physical flag count back to 4, both stages empty
// ----------------------------------------------------------------------------
// flag_register_bitmap_allocator
// free map, lock map and round-robin pointer for flag slot allocation
// ----------------------------------------------------------------------------
module flag_register_bitmap_allocator #(
    parameter int unsigned SLOT_COUNT = frba_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [frba_pkg::FLAG_COUNT_W-1:0]   i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  frba_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output frba_pkg::t_out_beat                 o_out_beat
);
    import frba_pkg::*;

    logic [FLAG_COUNT_W-1:0] r_flag_count;
    logic                    r_in_valid;
    t_in_beat                r_in_beat;
    logic                    r_out_valid;
    t_out_beat               r_out_beat;
    logic [SLOT_COUNT-1:0]   r_free_map;
    logic [LOCK_W-1:0]       r_lock_map;
    logic [2:0]              r_next_phys;

    logic [SLOT_COUNT-1:0]   n_free_map;
    logic [LOCK_W-1:0]       n_lock_map;
    logic [2:0]              n_next_phys;
    t_out_beat               n_out_beat;

    logic                    advance;
    logic                    pair;
    logic [3:0]              nflag;
    logic [2:0]              nflag_m1;
    logic [LOCK_W-1:0]       phys_mask;
    logic [LOCK_W-1:0]       unlocked;
    logic [LOCK_W-1:0]       unlocked_pair;
    logic [63:0]             idx_mask;
    logic                    idx_locked;
    logic [SLOT_COUNT-1:0]   alloc_cand;
    logic                    alloc_found;
    logic [SLOT_INDEX_W-1:0] alloc_base;
    logic [63:0]             alloc_mask;
    logic                    alloc_locked;
    logic                    asg_found;
    logic [2:0]              asg_idx;
    logic [3:0]              asg_i;
    logic [2:0]              asg_try;
    logic [LOCK_W-1:0]       asg_mask;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // effective physical flag count
    always_comb begin
        if (r_flag_count >= 4'd8) begin
            nflag     = 4'd8;
            nflag_m1  = 3'd7;
            phys_mask = 8'hFF;
        end else if (r_flag_count >= 4'd4) begin
            nflag     = 4'd4;
            nflag_m1  = 3'd3;
            phys_mask = 8'h0F;
        end else begin
            nflag     = 4'd2;
            nflag_m1  = 3'd1;
            phys_mask = 8'h03;
        end
    end

    assign pair          = (r_in_beat.slot_width == SLOT_WIDTH_PAIR);
    assign unlocked      = ~r_lock_map & phys_mask;
    assign unlocked_pair = unlocked & (unlocked >> 1) & LOCK_PAIR_MASK;

    // range at the given base, bits above the lock map count as unlocked
    assign idx_mask   = (pair ? 64'd3 : 64'd1) << r_in_beat.slot_index;
    assign idx_locked = (idx_mask[63:LOCK_W] == '0)
                        && ((idx_mask[LOCK_W-1:0] & ~r_lock_map) == '0);

    // lowest free slot or aligned pair
    assign alloc_cand = pair
        ? (r_free_map & (r_free_map >> 1) & PAIR_EVEN_MASK[SLOT_COUNT-1:0])
        : r_free_map;

    always_comb begin
        alloc_found = 1'b0;
        alloc_base  = '0;
        for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
            if (alloc_cand[j]) begin
                alloc_found = 1'b1;
                alloc_base  = SLOT_INDEX_W'(j);
            end
        end
    end

    assign alloc_mask   = (pair ? 64'd3 : 64'd1) << alloc_base;
    assign alloc_locked = (alloc_mask[63:LOCK_W] == '0)
                          && ((alloc_mask[LOCK_W-1:0] & ~r_lock_map) == '0);

    // round-robin search over the physical slots
    always_comb begin
        asg_found = 1'b0;
        asg_idx   = '0;
        asg_i     = '0;
        asg_try   = '0;
        asg_mask  = '0;
        for (int k = 0; k < LOCK_W; k++) begin
            asg_i   = {1'b0, r_next_phys} + 4'(k);
            asg_try = asg_i[2:0] & nflag_m1;
            asg_mask = (pair ? 8'd3 : 8'd1) << asg_try;
            if (!asg_found && (4'(k) < nflag) && !(pair && asg_i[0])
                    && ((r_lock_map & asg_mask) == '0)) begin
                asg_found = 1'b1;
                asg_idx   = asg_try;
            end
        end
    end

    always_comb begin
        n_free_map = r_free_map;
        n_lock_map = r_lock_map;
        n_next_phys = r_next_phys;
        n_out_beat = '0;
        unique case (r_in_beat.cmd) inside
            CMD_ALLOC_VIRTUAL, CMD_ALLOC_PHYSICAL: begin
                if (!alloc_found) begin
                    n_out_beat.status = STATUS_OUT_OF_SLOTS;
                end else if (r_in_beat.cmd == CMD_ALLOC_VIRTUAL) begin
                    n_free_map = r_free_map & ~alloc_mask[SLOT_COUNT-1:0];
                    n_out_beat.result_index = alloc_base;
                end else if ({2'b00, alloc_base} >= {4'd0, nflag}) begin
                    // virtual slot: claim undone, its lock bits dropped
                    n_lock_map = r_lock_map & ~alloc_mask[LOCK_W-1:0];
                    n_out_beat.status = STATUS_NOT_PHYSICAL;
                end else begin
                    n_free_map = r_free_map & ~alloc_mask[SLOT_COUNT-1:0];
                    n_lock_map = r_lock_map | alloc_mask[LOCK_W-1:0];
                    n_out_beat.result_index = alloc_base;
                    if (alloc_locked) begin
                        n_out_beat.status = STATUS_ILLEGAL_RELOCK;
                    end
                end
            end
            CMD_LOCK: begin
                n_lock_map = r_lock_map | idx_mask[LOCK_W-1:0];
                n_out_beat.result_index = r_in_beat.slot_index;
                n_out_beat.answer_bit   = idx_locked;
                if (idx_locked && !r_in_beat.allow_relock) begin
                    n_out_beat.status = STATUS_ILLEGAL_RELOCK;
                end
            end
            CMD_RELEASE: begin
                n_free_map = r_free_map | idx_mask[SLOT_COUNT-1:0];
                n_lock_map = r_lock_map & ~idx_mask[LOCK_W-1:0];
                n_out_beat.result_index = r_in_beat.slot_index;
            end
            CMD_CAN_LOCK: begin
                n_out_beat.answer_bit = pair ? (unlocked_pair != '0) : (unlocked != '0);
            end
            CMD_FREE_UNLOCKED: begin
                n_free_map = r_free_map & ~{{(SLOT_COUNT-LOCK_W){1'b0}}, unlocked};
            end
            CMD_ASSIGN_PHYSICAL: begin
                if (asg_found) begin
                    n_next_phys = (asg_idx + (pair ? 3'd2 : 3'd1)) & nflag_m1;
                    n_out_beat.result_index = {{(SLOT_INDEX_W-3){1'b0}}, asg_idx};
                end else begin
                    n_out_beat.status = STATUS_OUT_OF_SLOTS;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_count <= FLAG_COUNT_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_free_map   <= '1;
            r_lock_map   <= '0;
            r_next_phys  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_flag_count <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_free_map  <= n_free_map;
                r_lock_map  <= n_lock_map;
                r_next_phys <= n_next_phys;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
        if (advance) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule

// ----- rtl/frba_checker.sv -----
// ----------------------------------------------------------------------------
// frba_checker
// port level checks of the flag slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "flag_register_bitmap_allocator_assert.svh"

module frba_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  frba_pkg::t_out_beat                 o_out_beat
);
    import frba_pkg::*;

    // stalled result beat holds
    `FRBA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))

    // input only backs up behind a waiting result
    `FRBA_ASSERT(a_ready_backpressure, !o_in_ready |-> o_out_valid && !i_out_ready)

    // an accepted beat leads to a result beat waiting on the output
    `FRBA_ASSERT(a_accept_result, i_in_valid && o_in_ready |-> ##2 o_out_valid)

    // failed allocation or virtual claim reports base zero
    `FRBA_ASSERT_MSG(a_fail_index_zero, o_out_valid && (o_out_beat.status == STATUS_OUT_OF_SLOTS || o_out_beat.status == STATUS_NOT_PHYSICAL) |-> o_out_beat.result_index == '0, "failure beat with nonzero index")

    // answer bit only with ok or relock status
    `FRBA_ASSERT(a_answer_status, o_out_valid && o_out_beat.answer_bit |-> o_out_beat.status == STATUS_OK || o_out_beat.status == STATUS_ILLEGAL_RELOCK)

endmodule

bind flag_register_bitmap_allocator frba_checker u_frba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_beat   (o_out_beat)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// flag register bitmap allocator testbench
// directed command script, then random commands and alloc/lock/release
// lifecycles under several flag counts and idle patterns, each result beat
// checked against a scripted result or the in-bench model of maps and pointer
// ----------------------------------------------------------------------------
module tb;
    import frba_pkg::*;

    localparam logic [2:0]  CMD_UNUSED  = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_BEATS = 225;
    localparam int unsigned PHASES      = 8;
    localparam logic [31:0] FLAG_PLAN   = {4'd4, 4'd9, 4'd3, 4'd7, 4'd0, 4'd15, 4'd2, 4'd8};

    typedef struct packed {
        t_in_beat  beat;
        logic      checked;
        t_out_beat outcome;
    } t_script_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [FLAG_COUNT_W-1:0] i_cfg_wr_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_in_beat                i_in_beat;
    logic                    o_out_valid;
    logic                    i_out_ready;
    t_out_beat               o_out_beat;

    // model state
    logic [63:0]             free_slots;
    logic [LOCK_W-1:0]       locked_flags;
    logic [2:0]              rr_next;
    logic [FLAG_COUNT_W-1:0] flag_count;

    t_out_beat   expected_outcomes[$];
    t_script_row script_rows[$];
    t_out_beat   arrived;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned beats_sent;

    flag_register_bitmap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_beat     (i_in_beat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_beat    (o_out_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] slot_span(input logic [5:0] base, input int unsigned width);
        return ((width == 2) ? 64'd3 : 64'd1) << base;
    endfunction

    function automatic bit all_locked(input logic [63:0] span);
        return (span & ~{56'd0, locked_flags}) == 64'd0;
    endfunction

    function automatic t_out_beat run_command(input t_in_beat b);
        t_out_beat         r;
        logic [63:0]       avail;
        logic [63:0]       span;
        logic [LOCK_W-1:0] open_flags;
        int unsigned       width;
        int unsigned       nflag;
        int unsigned       idx;
        int                base;
        bit                was;
        bit                found;
        r = '0;
        width = (b.slot_width == SLOT_WIDTH_PAIR) ? 2 : 1;
        nflag = (flag_count >= 8) ? 8 : (flag_count >= 4) ? 4 : 2;
        open_flags = ~locked_flags & LOCK_W'((1 << nflag) - 1);
        span = slot_span(b.slot_index, width);
        case (b.cmd) inside
            CMD_ALLOC_VIRTUAL, CMD_ALLOC_PHYSICAL: begin
                avail = free_slots;
                if (width == 2) avail = avail & (avail >> 1) & PAIR_EVEN_MASK;
                base = -1;
                for (int i = 63; i >= 0; i--) if (avail[i]) base = i;
                if (base < 0) begin
                    r.status = STATUS_OUT_OF_SLOTS;
                end else begin
                    span = slot_span(6'(base), width);
                    free_slots &= ~span;
                    r.result_index = 6'(base);
                    if (b.cmd == CMD_ALLOC_PHYSICAL) begin
                        if (base >= nflag) begin
                            // virtual slot: claim undone
                            free_slots |= span;
                            locked_flags &= ~span[LOCK_W-1:0];
                            r.status = STATUS_NOT_PHYSICAL;
                            r.result_index = '0;
                        end else begin
                            if (all_locked(span)) r.status = STATUS_ILLEGAL_RELOCK;
                            locked_flags |= span[LOCK_W-1:0];
                        end
                    end
                end
            end
            CMD_LOCK: begin
                was = all_locked(span);
                if (was && !b.allow_relock) r.status = STATUS_ILLEGAL_RELOCK;
                locked_flags |= span[LOCK_W-1:0];
                r.answer_bit = was;
                r.result_index = b.slot_index;
            end
            CMD_RELEASE: begin
                free_slots |= span;
                locked_flags &= ~span[LOCK_W-1:0];
                r.result_index = b.slot_index;
            end
            CMD_CAN_LOCK: begin
                if (width == 2) open_flags = open_flags & (open_flags >> 1) & LOCK_PAIR_MASK;
                r.answer_bit = (open_flags != '0);
            end
            CMD_FREE_UNLOCKED: begin
                free_slots &= ~{56'd0, open_flags};
            end
            CMD_ASSIGN_PHYSICAL: begin
                found = 1'b0;
                for (int unsigned i = rr_next; i < rr_next + nflag; i++) begin
                    if (!found && (i & (width - 1)) == 0) begin
                        idx = i & (nflag - 1);
                        span = slot_span(6'(idx), width);
                        if ((locked_flags & span[LOCK_W-1:0]) == '0) begin
                            rr_next = 3'((idx + width) & (nflag - 1));
                            r.result_index = 6'(idx);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) r.status = STATUS_OUT_OF_SLOTS;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20)      b.cmd = CMD_ALLOC_VIRTUAL;
        else if (pick < 35) b.cmd = CMD_ALLOC_PHYSICAL;
        else if (pick < 50) b.cmd = CMD_LOCK;
        else if (pick < 70) b.cmd = CMD_RELEASE;
        else if (pick < 79) b.cmd = CMD_CAN_LOCK;
        else if (pick < 84) b.cmd = CMD_FREE_UNLOCKED;
        else if (pick < 96) b.cmd = CMD_ASSIGN_PHYSICAL;
        else                b.cmd = CMD_UNUSED;
        b.slot_width = ($urandom_range(99) < 45) ? SLOT_WIDTH_PAIR : 2'($urandom_range(3));
        b.slot_index = ($urandom_range(1) == 1) ? 6'($urandom_range(9)) : 6'($urandom_range(63));
        b.allow_relock = 1'($urandom_range(1));
        return b;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [1:0] width, input logic [5:0] idx,
                           input logic allow, input logic checked, input logic [1:0] st,
                           input logic [5:0] res, input logic ans);
        t_script_row row;
        row.beat.cmd            = cmd;
        row.beat.slot_width     = width;
        row.beat.slot_index     = idx;
        row.beat.allow_relock   = allow;
        row.checked             = checked;
        row.outcome.status      = st;
        row.outcome.result_index = res;
        row.outcome.answer_bit  = ans;
        script_rows.push_back(row);
    endtask

    task automatic send_beat(input t_in_beat b, input logic checked, input t_out_beat fixed,
                             output t_out_beat outcome);
        t_out_beat predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        predicted = run_command(b);
        outcome = checked ? fixed : predicted;
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_outcomes.push_back(outcome);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_outcomes.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_flag_count(input logic [FLAG_COUNT_W-1:0] value);
        drain_results();
        repeat (3) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        flag_count = value;
    endtask

    // alloc or assign, then on success maybe lock, query, release the same range
    task automatic run_lifecycle();
        t_in_beat  b;
        t_out_beat got;
        t_out_beat ignored;
        b = random_beat();
        case ($urandom_range(2))
            0:       b.cmd = CMD_ALLOC_VIRTUAL;
            1:       b.cmd = CMD_ALLOC_PHYSICAL;
            default: b.cmd = CMD_ASSIGN_PHYSICAL;
        endcase
        send_beat(b, 1'b0, '0, got);
        if (got.status == STATUS_OK || got.status == STATUS_ILLEGAL_RELOCK) begin
            b.slot_index = got.result_index;
            if ($urandom_range(1) == 1) begin
                b.cmd = CMD_LOCK;
                b.allow_relock = 1'($urandom_range(1));
                send_beat(b, 1'b0, '0, ignored);
            end
            if ($urandom_range(3) == 0) begin
                b.cmd = CMD_CAN_LOCK;
                send_beat(b, 1'b0, '0, ignored);
            end
            if ($urandom_range(99) < 65) begin
                b.cmd = CMD_RELEASE;
                send_beat(b, 1'b0, '0, ignored);
            end
        end
    endtask

    task automatic check_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                $error("result beat with no expectation waiting");
            end else begin
                arrived = expected_outcomes.pop_front();
                check_field("status", arrived.status, o_out_beat.status);
                check_field("result_index", arrived.result_index, o_out_beat.result_index);
                check_field("answer_bit", arrived.answer_bit, o_out_beat.answer_bit);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_in_beat    b;
        t_out_beat   ignored;
        int unsigned phase_start;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_in_beat      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        mismatches     = 0;
        beats_sent     = 0;
        free_slots     = '1;
        locked_flags   = '0;
        rr_next        = '0;
        flag_count     = FLAG_COUNT_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_flag_count(FLAG_COUNT_RESET);

        // directed script, flag count 4
        add_row(CMD_CAN_LOCK,        2'd1, 6'd0,  1'b0, 1'b1, STATUS_OK, 6'd0, 1'b1);
        add_row(CMD_ALLOC_VIRTUAL,   2'd1, 6'd0,  1'b0, 1'b1, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_ALLOC_VIRTUAL,   2'd2, 6'd0,  1'b0, 1'b1, STATUS_OK, 6'd2, 1'b0);
        add_row(CMD_ALLOC_PHYSICAL,  2'd1, 6'd0,  1'b0, 1'b1, STATUS_OK, 6'd1, 1'b0);
        add_row(CMD_LOCK,            2'd1, 6'd1,  1'b0, 1'b1, STATUS_ILLEGAL_RELOCK, 6'd1, 1'b1);
        add_row(CMD_LOCK,            2'd1, 6'd1,  1'b1, 1'b1, STATUS_OK, 6'd1, 1'b1);
        add_row(CMD_LOCK,            2'd2, 6'd63, 1'b0, 1'b1, STATUS_OK, 6'd63, 1'b0);
        add_row(CMD_ALLOC_PHYSICAL,  2'd2, 6'd0,  1'b0, 1'b1, STATUS_NOT_PHYSICAL, 6'd0, 1'b0);
        add_row(CMD_UNUSED,          2'd3, 6'd63, 1'b1, 1'b1, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_ASSIGN_PHYSICAL, 2'd1, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_ASSIGN_PHYSICAL, 2'd2, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_CAN_LOCK,        2'd2, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_FREE_UNLOCKED,   2'd0, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd0, 6'd0,  1'b1, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd3, 6'd5,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd2, 6'd7,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_RELEASE,         2'd2, 6'd62, 1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_RELEASE,         2'd1, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd1, 6'd0,  1'b1, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_ALLOC_PHYSICAL,  2'd1, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd2, 6'd0,  1'b1, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_LOCK,            2'd2, 6'd2,  1'b1, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_ASSIGN_PHYSICAL, 2'd1, 6'd0,  1'b0, 1'b1, STATUS_OUT_OF_SLOTS, 6'd0, 1'b0);
        add_row(CMD_CAN_LOCK,        2'd2, 6'd0,  1'b0, 1'b1, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_RELEASE,         2'd2, 6'd0,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        add_row(CMD_RELEASE,         2'd2, 6'd2,  1'b0, 1'b0, STATUS_OK, 6'd0, 1'b0);
        foreach (script_rows[k])
            send_beat(script_rows[k].beat, script_rows[k].checked, script_rows[k].outcome,
                      ignored);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            set_flag_count(FLAG_PLAN[phase*4 +: 4]);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            phase_start = beats_sent;
            if (phase % 2 == 0) begin
                // fill the map past exhaustion
                repeat (70) begin
                    b = random_beat();
                    b.cmd = CMD_ALLOC_VIRTUAL;
                    send_beat(b, 1'b0, '0, ignored);
                end
            end else begin
                for (int unsigned p = 0; p < 64; p += 2) begin
                    b = random_beat();
                    b.cmd = CMD_RELEASE;
                    b.slot_width = SLOT_WIDTH_PAIR;
                    b.slot_index = 6'(p);
                    send_beat(b, 1'b0, '0, ignored);
                end
            end
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if ($urandom_range(99) == 0) drain_results();
                if ($urandom_range(99) < 60) begin
                    run_lifecycle();
                end else begin
                    send_beat(random_beat(), 1'b0, '0, ignored);
                end
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
